// ===== hw/rtl/chkv_pkg.sv =====
// ----------------------------------------------------------------------------
// chkv_pkg
// Codes and constants of the chained hash key-value table.
// ----------------------------------------------------------------------------
package chkv_pkg;

  // request actions
  localparam logic [1:0] ACT_PUT    = 2'd0;
  localparam logic [1:0] ACT_GET    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_MISSING  = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  // fmix64 constants
  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

  // value returned when nothing is read
  localparam logic [7:0] NO_VALUE = 8'hFF;

  typedef logic [1:0]        action_t;
  typedef logic signed [63:0] key_t;
  typedef logic signed [7:0]  data_t;
  typedef logic [2:0]        status_t;
  typedef logic [10:0]       count_t;

endpackage

// ===== hw/rtl/chkv_req_if.sv =====
// ----------------------------------------------------------------------------
// chkv_req_if
// Request channel: action, key and value with valid/ready.
// ----------------------------------------------------------------------------
interface chkv_req_if;
  import chkv_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  key_t    key;
  data_t   value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

// ===== hw/rtl/chkv_rsp_if.sv =====
// ----------------------------------------------------------------------------
// chkv_rsp_if
// Result channel: status, read value and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface chkv_rsp_if;
  import chkv_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  data_t   read_value;
  count_t  entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

// ===== hw/rtl/chained_hash_key_value_table.sv =====
// ----------------------------------------------------------------------------
// chained_hash_key_value_table
// Key-value map over BUCKETS chained buckets and a pool of ENTRIES entries.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (action, key, value); rsp returns exactly one
//   result (status, read_value, entry_count) per request, in order.
//   One request is worked on at a time. Its steps, in order: accept, the
//   two fmix products on the shared 32x32 multiplier, the bucket index
//   (16 hash bits per step, a reciprocal multiply then one correction),
//   the bucket head read, one entry read per chain entry visited, the
//   chain end on a miss, a free-stack read and write for an insert, and
//   the result. Clear sweeps the head memory, one bucket a cycle.
//   After reset the same sweep runs with req.ready low.
//   A finished result sits in the output register; the next request is
//   accepted while it waits. If rsp stalls, the following result waits
//   in its final step until the register frees up.
// ----------------------------------------------------------------------------
module chained_hash_key_value_table #(
  parameter int BUCKETS = 1024,
  parameter int ENTRIES = 1024
) (
  input logic      clk,
  input logic      rst,
  chkv_req_if.sink   req,
  chkv_rsp_if.source rsp
);
  import chkv_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IW = $clog2(ENTRIES);
  localparam int PW = $clog2(ENTRIES + 1);
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);
  // floor(2^32 / BUCKETS) for the reciprocal bucket reduction
  localparam logic [31:0] MOD_M = 32'(64'h1_0000_0000 / 64'(BUCKETS));

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_MOD  = 4'd2;
  localparam logic [3:0] S_HEAD = 4'd3;
  localparam logic [3:0] S_HCAP = 4'd4;
  localparam logic [3:0] S_WALK = 4'd5;
  localparam logic [3:0] S_ECHK = 4'd6;
  localparam logic [3:0] S_FPOP = 4'd7;
  localparam logic [3:0] S_FWR  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_CLR  = 4'd10;

  logic [3:0] state;
  logic       init_pass;

  // latched request
  action_t     act;
  logic [63:0] key;
  logic [7:0]  val;

  // hash datapath
  logic [63:0] mul_in;
  logic [63:0] acc;
  logic [1:0]  mstep;
  logic        mpass;
  logic [63:0] hreg;
  logic [1:0]  mod_cnt;
  logic        mod_ph;
  logic [31:0] mod_t;
  logic [15:0] mod_q;
  logic [BW-1:0] bucket;

  // walk state
  logic [PW-1:0] cur;
  logic [PW-1:0] prev;
  logic [PW-1:0] steps;
  logic [PW-1:0] head_val;

  // pool bookkeeping
  logic [PW-1:0] free_top;
  logic [PW-1:0] low_water;
  logic [PW-1:0] stored_count;
  logic [BW-1:0] clr_idx;

  // pending result
  status_t res_status;
  logic [7:0] res_rv;

  // output register
  logic    out_valid;
  status_t out_status;
  logic [7:0] out_rv;
  count_t  out_count;

  // memories
  logic [PW-1:0] head_mem [BUCKETS];
  logic [63:0]   key_mem  [ENTRIES];
  logic [7:0]    data_mem [ENTRIES];
  logic [PW-1:0] link_mem [ENTRIES];
  logic [IW-1:0] fs_mem   [ENTRIES];

  logic [PW-1:0] head_q;
  logic [63:0]   key_q;
  logic [7:0]    data_q;
  logic [PW-1:0] link_q;
  logic [IW-1:0] fs_q;

  // ---------------------------------------------------------------- hash math
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] mul_c;
  logic [63:0] acc_sum;
  logic [63:0] mix_out;

  always_comb begin
    mul_c = mpass ? MIX_C2 : MIX_C1;
    case (mstep)
      2'd0: begin
        mul_a = mul_in[31:0];
        mul_b = mul_c[31:0];
      end
      2'd1: begin
        mul_a = mul_in[63:32];
        mul_b = mul_c[31:0];
      end
      default: begin
        mul_a = mul_in[31:0];
        mul_b = mul_c[63:32];
      end
    endcase
    // bucket reduction borrows the multiplier for its quotient estimate
    if (state == S_MOD) begin
      mul_a = mod_t;
      mul_b = MOD_M;
    end
    mul_p   = 64'(mul_a) * 64'(mul_b);
    acc_sum = acc + {mul_p[31:0], 32'd0};
    mix_out = acc_sum ^ (acc_sum >> MIX_SHIFT);
  end

  // remainder of one 32-bit partial: estimate is low by at most one
  logic [31:0]   mod_diff;
  logic [BW-1:0] rem_next;

  always_comb begin
    mod_diff = mod_t - 32'(mod_q) * 32'(BUCKETS);
    if (mod_diff >= 32'(BUCKETS)) begin
      rem_next = BW'(mod_diff - 32'(BUCKETS));
    end else begin
      rem_next = BW'(mod_diff);
    end
  end

  // ----------------------------------------------------------- decisions
  logic walk_miss;
  logic walk_more;
  logic key_hit;
  logic out_free;
  logic load_out;
  logic [PW-1:0] pop_slot;
  logic [IW-1:0] pop_entry;

  always_comb begin
    walk_miss = (state == S_WALK) && ((cur >= NIL) || (steps == NIL));
    walk_more = (state == S_WALK) && !walk_miss;
    key_hit   = (state == S_ECHK) && (key_q == key);
    out_free  = !out_valid || rsp.ready;
    load_out  = (state == S_FIN) && out_free;
    pop_slot  = free_top - PW'(1);
    // slots below the low-water mark were never written since the last clear
    pop_entry = (pop_slot < low_water) ? pop_slot[IW-1:0] : fs_q;
  end

  // memory write controls
  logic          head_we;
  logic [BW-1:0] head_wa;
  logic [PW-1:0] head_wd;
  logic          ent_we;
  logic          data_we;
  logic [IW-1:0] data_wa;
  logic          link_we;
  logic [IW-1:0] link_wa;
  logic [PW-1:0] link_wd;
  logic          fs_we;

  always_comb begin
    head_we = 1'b0;
    head_wa = bucket;
    head_wd = NIL;
    ent_we  = 1'b0;
    data_we = 1'b0;
    data_wa = cur[IW-1:0];
    link_we = 1'b0;
    link_wa = pop_entry;
    link_wd = head_val;
    fs_we   = 1'b0;
    if (state == S_CLR) begin
      head_we = 1'b1;
      head_wa = clr_idx;
    end
    if (key_hit && act == ACT_PUT) begin
      data_we = 1'b1;
    end
    if (key_hit && act == ACT_REMOVE) begin
      if (prev < NIL) begin
        link_we = 1'b1;
        link_wa = prev[IW-1:0];
        link_wd = link_q;
      end else begin
        head_we = 1'b1;
        head_wd = link_q;
      end
      fs_we = (free_top < NIL);
    end
    if (state == S_FWR) begin
      ent_we  = 1'b1;
      data_we = 1'b1;
      data_wa = pop_entry;
      link_we = 1'b1;
      head_we = 1'b1;
      head_wd = PW'(pop_entry);
    end
  end

  // head memory
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_q <= head_mem[bucket];
  end

  // entry memories
  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[pop_entry] <= key;
    end
    if (data_we) begin
      data_mem[data_wa] <= val;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    key_q  <= key_mem[cur[IW-1:0]];
    data_q <= data_mem[cur[IW-1:0]];
    link_q <= link_mem[cur[IW-1:0]];
  end

  // free stack
  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[free_top[IW-1:0]] <= cur[IW-1:0];
    end
    fs_q <= fs_mem[pop_slot[IW-1:0]];
  end

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      init_pass    <= 1'b1;
      clr_idx      <= '0;
      free_top     <= NIL;
      low_water    <= NIL;
      stored_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (rsp.ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            act    <= req.action;
            key    <= req.key;
            val    <= req.value;
            mul_in <= req.key ^ (req.key >> MIX_SHIFT);
            mstep  <= 2'd0;
            mpass  <= 1'b0;
            clr_idx <= '0;
            state  <= (req.action == ACT_CLEAR) ? S_CLR : S_MUL;
          end
        end
        S_MUL: begin
          case (mstep)
            2'd0: begin
              acc   <= mul_p;
              mstep <= 2'd1;
            end
            2'd1: begin
              acc   <= acc_sum;
              mstep <= 2'd2;
            end
            default: begin
              mstep <= 2'd0;
              if (!mpass) begin
                mul_in <= mix_out;
                mpass  <= 1'b1;
              end else begin
                hreg    <= {mix_out[47:0], 16'd0};
                mod_t   <= {16'd0, mix_out[63:48]};
                mod_ph  <= 1'b0;
                mod_cnt <= '0;
                state   <= S_MOD;
              end
            end
          endcase
        end
        // 16 hash bits per step, most significant first
        S_MOD: begin
          if (!mod_ph) begin
            mod_q  <= mul_p[47:32];
            mod_ph <= 1'b1;
          end else begin
            mod_ph  <= 1'b0;
            mod_cnt <= mod_cnt + 2'd1;
            mod_t   <= {16'(rem_next), hreg[63:48]};
            hreg    <= {hreg[47:0], 16'd0};
            if (mod_cnt == 2'd3) begin
              bucket <= rem_next;
              state  <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          state <= S_HCAP;
        end
        S_HCAP: begin
          cur      <= head_q;
          head_val <= head_q;
          prev     <= NIL;
          steps    <= '0;
          state    <= S_WALK;
        end
        S_WALK: begin
          if (walk_more) begin
            state <= S_ECHK;
          end else begin
            res_rv <= NO_VALUE;
            if (act == ACT_PUT) begin
              if (free_top == '0) begin
                res_status <= ST_FULL;
                state      <= S_FIN;
              end else begin
                state <= S_FPOP;
              end
            end else begin
              res_status <= ST_MISSING;
              state      <= S_FIN;
            end
          end
        end
        S_ECHK: begin
          if (key_hit) begin
            state <= S_FIN;
            case (act)
              ACT_PUT: begin
                res_status <= ST_UPDATED;
                res_rv     <= NO_VALUE;
              end
              ACT_GET: begin
                res_status <= ST_FOUND;
                res_rv     <= data_q;
              end
              default: begin
                res_status <= ST_REMOVED;
                res_rv     <= NO_VALUE;
                if (free_top < NIL) begin
                  free_top <= free_top + PW'(1);
                end
                if (stored_count != '0) begin
                  stored_count <= stored_count - PW'(1);
                end
              end
            endcase
          end else begin
            prev  <= cur;
            cur   <= link_q;
            steps <= steps + PW'(1);
            state <= S_WALK;
          end
        end
        S_FPOP: begin
          state <= S_FWR;
        end
        S_FWR: begin
          free_top     <= pop_slot;
          stored_count <= stored_count + PW'(1);
          if (pop_slot < low_water) begin
            low_water <= pop_slot;
          end
          res_status <= ST_INSERTED;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_rv     <= res_rv;
            out_count  <= 11'(stored_count);
            state      <= S_IDLE;
          end
        end
        S_CLR: begin
          clr_idx <= clr_idx + BW'(1);
          if (clr_idx == BW'(BUCKETS - 1)) begin
            free_top     <= NIL;
            low_water    <= NIL;
            stored_count <= '0;
            res_status   <= ST_CLEARED;
            res_rv       <= NO_VALUE;
            init_pass    <= 1'b0;
            state        <= init_pass ? S_IDLE : S_FIN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_value  = out_rv;
  assign rsp.entry_count = out_count;

  // ------------------------------------------------------------ assertions
  // every entry is either stored or on the free stack
  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    (32'(free_top) + 32'(stored_count)) == ENTRIES)
    else $error("pool accounting out of balance");

  // the low-water mark never rises above the stack top
  a_low_water: assert property (@(posedge clk) disable iff (rst)
    low_water <= free_top)
    else $error("free stack low-water mark above top");

  // a finished result reaches the output register once that register is free
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && out_free |=> rsp.valid && (state == S_IDLE))
    else $error("result not loaded into output register");

  // the reset sweep produces no result
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    init_pass |-> !rsp.valid)
    else $error("result produced during reset sweep");

endmodule

// ===== sim/chained_hash_key_value_table_tb.sv =====
// ----------------------------------------------------------------------------
// chained_hash_key_value_table_tb
// Drives put/get/remove/clear requests into the chained hash table with
// random gaps and result stalls. A scoreboard holds its own copy of the map
// (buckets by fmix64 hash, free stack, chains) and checks every result.
// ----------------------------------------------------------------------------
module chained_hash_key_value_table_tb;
  import chkv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUCKETS = 1024;
  localparam int ENTRIES = 1024;
  localparam int NIL = ENTRIES;
  localparam int LIMIT = 4_000_000;

  typedef struct packed {
    status_t status;
    data_t   read_value;
    count_t  entry_count;
  } outcome_t;

  // table model and queue of expected outcomes
  class table_scoreboard;
    int        head[BUCKETS];
    key_t      ekey[ENTRIES];
    data_t     edata[ENTRIES];
    int        elink[ENTRIES];
    int        free_stack[ENTRIES];
    int        free_top;
    int        stored;
    outcome_t  pending[$];
    int        errors;

    function new();
      errors = 0;
      empty_all();
    endfunction

    function void empty_all();
      for (int i = 0; i < BUCKETS; i++) head[i] = NIL;
      for (int i = 0; i < ENTRIES; i++) free_stack[i] = i;
      free_top = ENTRIES;
      stored = 0;
    endfunction

    function int bucket_of(logic [63:0] k);
      logic [63:0] h;
      h = k;
      h ^= h >> MIX_SHIFT;
      h = h * MIX_C1;
      h ^= h >> MIX_SHIFT;
      h = h * MIX_C2;
      h ^= h >> MIX_SHIFT;
      return int'(h % BUCKETS);
    endfunction

    // note an accepted request and queue its outcome
    function void note_request(action_t act, key_t k, data_t v);
      outcome_t o;
      int b, cur, prv, hit, steps, e;
      o.read_value = NO_VALUE;
      b = bucket_of(k);
      if (act == ACT_CLEAR) begin
        empty_all();
        o.status = ST_CLEARED;
      end else begin
        cur = head[b]; prv = NIL; hit = NIL; steps = 0;
        while (cur < NIL && steps < ENTRIES) begin
          if (ekey[cur] == k) begin
            hit = cur;
            break;
          end
          prv = cur;
          cur = elink[cur];
          steps++;
        end
        if (act == ACT_PUT) begin
          if (hit < NIL) begin
            edata[hit] = v;
            o.status = ST_UPDATED;
          end else if (free_top == 0) begin
            o.status = ST_FULL;
          end else begin
            free_top--;
            e = free_stack[free_top];
            ekey[e] = k; edata[e] = v; elink[e] = head[b];
            head[b] = e;
            stored++;
            o.status = ST_INSERTED;
          end
        end else if (act == ACT_GET) begin
          if (hit < NIL) begin
            o.read_value = edata[hit];
            o.status = ST_FOUND;
          end else begin
            o.status = ST_MISSING;
          end
        end else begin
          if (hit < NIL) begin
            if (prv < NIL) elink[prv] = elink[hit];
            else head[b] = elink[hit];
            free_stack[free_top] = hit;
            free_top++;
            stored--;
            o.status = ST_REMOVED;
          end else begin
            o.status = ST_MISSING;
          end
        end
      end
      o.entry_count = count_t'(stored);
      pending.push_back(o);
    endfunction

    function void check_result(status_t s, data_t rv, count_t n);
      outcome_t o;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result status=%0d", s));
        return;
      end
      o = pending.pop_front();
      if (s !== o.status)
        report($sformatf("status %0d, expected %0d", s, o.status));
      if (rv !== o.read_value)
        report($sformatf("read_value %0d, expected %0d", rv, o.read_value));
      if (n !== o.entry_count)
        report($sformatf("entry_count %0d, expected %0d", n, o.entry_count));
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 50) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle = 0;

  chkv_req_if req();
  chkv_rsp_if rsp();

  chained_hash_key_value_table #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  table_scoreboard board = new();
  key_t key_pool[$];
  bit   sending_done = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.action = ACT_GET;
    req.key = '0;
    req.value = '0;
    rsp.ready = 1'b0;
  end

  // timeout
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT) begin
      $display("timeout waiting for results");
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, check on handshake
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk iff rsp.valid);
      board.check_result(rsp.status, rsp.read_value, rsp.entry_count);
    end
  end

  task automatic send_request(action_t act, key_t k, data_t v, int gap);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.key <= k;
    req.value <= v;
    @(posedge clk iff req.ready);
    board.note_request(act, k, v);
  endtask

  // stop sending and hold off until every result is back
  task automatic drain_results();
    req.valid <= 1'b0;
    @(posedge clk);
    wait (board.pending.size() == 0);
  endtask

  function automatic key_t fresh_key();
    key_t k;
    k = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: k = 64'h8000_0000_0000_0000;
      1: k = 64'h7FFF_FFFF_FFFF_FFFF;
      2: k = key_t'($urandom_range(0, 15));
      3: k = -key_t'($urandom_range(1, 16));
      default: ;
    endcase
    return k;
  endfunction

  function automatic key_t pick_key();
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return fresh_key();
  endfunction

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  initial begin
    key_t k;
    int   act_pick;
    action_t act;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, -1 data, remove missing, clear
    send_request(ACT_GET, 64'h8000_0000_0000_0000, 8'sd0, 0);
    send_request(ACT_PUT, 64'h8000_0000_0000_0000, -8'sd128, 0);
    send_request(ACT_PUT, 64'h7FFF_FFFF_FFFF_FFFF, 8'sd127, 1);
    send_request(ACT_PUT, 64'h0, -8'sd1, 0);
    send_request(ACT_PUT, -64'sd1, 8'sh55, 0);
    send_request(ACT_GET, 64'h0, 8'sd0, 0);
    send_request(ACT_GET, 64'h8000_0000_0000_0000, 8'sd0, 2);
    send_request(ACT_GET, 64'h7FFF_FFFF_FFFF_FFFF, 8'sd0, 0);
    send_request(ACT_PUT, 64'h0, 8'sh2A, 0);
    send_request(ACT_GET, 64'h0, 8'sd0, 0);
    send_request(ACT_REMOVE, 64'h1234, 8'sd0, 0);
    send_request(ACT_REMOVE, -64'sd1, 8'sd0, 0);
    send_request(ACT_GET, -64'sd1, 8'sd0, 0);
    send_request(ACT_CLEAR, 64'h0, 8'sd0, 3);
    send_request(ACT_GET, 64'h7FFF_FFFF_FFFF_FFFF, 8'sd0, 0);

    // fill the pool past capacity to reach the full status
    for (int i = 0; i < ENTRIES + 6; i++)
      send_request(ACT_PUT, {$urandom(), $urandom()}, data_t'($urandom()), 0);
    send_request(ACT_GET, 64'h5, 8'sd0, 0);
    // hold off until every result is back
    drain_results();
    send_request(ACT_CLEAR, 64'h0, 8'sd0, 0);

    // random traffic over a small key set so chains collide and hits are common
    for (int i = 0; i < 450; i++) begin
      act_pick = $urandom_range(0, 99);
      if (act_pick < 45) act = ACT_PUT;
      else if (act_pick < 75) act = ACT_GET;
      else if (act_pick < 98) act = ACT_REMOVE;
      else act = ACT_CLEAR;
      k = (act == ACT_PUT && $urandom_range(0, 1)) ? fresh_key() : pick_key();
      if (act == ACT_PUT && key_pool.size() < 64) key_pool.push_back(k);
      send_request(act, k, data_t'($urandom()), (i % 200 < 20) ? 0 : draw_gap());
      if (i == 200) drain_results();
    end
    req.valid <= 1'b0;
    sending_done = 1;
  end

  // end of run
  initial begin
    wait (sending_done);
    wait (board.pending.size() == 0);
    repeat (BUCKETS + 100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
